@@ hw/rtl/clns_pkg.sv @@
package clns_pkg;

	// Request codes carried on the input tuser field.
	localparam logic [2:0] ACT_TICK   = 3'd0;
	localparam logic [2:0] ACT_CMD    = 3'd1;
	localparam logic [2:0] ACT_CHAR   = 3'd2;
	localparam logic [2:0] ACT_GOTO   = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W   = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POWER  = 3'd3;

	localparam logic [15:0] RST_PULSE  = 16'd1;
	localparam logic [15:0] RST_GAP    = 16'd200;
	localparam logic [15:0] RST_SETTLE = 16'd2000;
	localparam logic [15:0] RST_POWER  = 16'd20000;

	// Display geometry and command bytes.
	localparam int unsigned COLUMNS    = 16;
	localparam logic [7:0] ROW0_BASE   = 8'h80;
	localparam logic [7:0] ROW1_BASE   = 8'hC0;
	localparam logic [7:0] CMD_CLEAR   = 8'h01;
	localparam logic [7:0] CMD_HOME    = 8'h80;
	localparam logic [2:0] INIT_COUNT  = 3'd7;
	localparam logic [2:0] INIT_EXTRA  = 3'd5;

	// Queue between the decode side and the sequencer.
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		PH_POWER,
		PH_HIGH,
		PH_GAP,
		PH_LOW,
		PH_SETTLE,
		PH_EXTRA,
		PH_IDLE
	} phase_t;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_START,
		OP_CLEAR,
		OP_NONE
	} op_kind_t;

	// One classified item as it travels through the queue.
	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  byte_val;
		logic        rs;
	} op_t;

	// Initialisation byte sequence.
	function automatic logic [7:0] init_byte(input logic [2:0] step);
		logic [7:0] b;
		case (step)
			3'd0: b = 8'h33;
			3'd1: b = 8'h32;
			3'd2: b = 8'h28;
			3'd3: b = 8'h0C;
			3'd4: b = 8'h06;
			3'd5: b = 8'h01;
			default: b = 8'h80;
		endcase
		return b;
	endfunction

endpackage

@@ hw/rtl/clns_front.sv @@
module clns_front
	import clns_pkg::*;
(
	input  logic [2:0]  action,
	input  logic [7:0]  byte_value,
	input  logic [1:0]  row,
	input  logic [4:0]  column,
	output op_t         op
);

	logic       goto_ok;
	logic [7:0] goto_byte;

	// Goto acts only on the two rows and on columns that exist.
	assign goto_ok   = ({1'b0, column} < 6'(COLUMNS)) && (row <= 2'd1);
	assign goto_byte = ((row == 2'd0) ? ROW0_BASE : ROW1_BASE) | {3'b000, column};

	// Classify the item into the operation the sequencer carries out.
	always_comb begin
		op.kind     = OP_NONE;
		op.byte_val = byte_value;
		op.rs       = 1'b0;
		case (action)
			ACT_TICK: begin
				op.kind = OP_TICK;
			end
			ACT_CMD: begin
				op.kind = OP_START;
			end
			ACT_CHAR: begin
				op.kind = OP_START;
				op.rs   = 1'b1;
			end
			ACT_GOTO: begin
				op.kind     = goto_ok ? OP_START : OP_NONE;
				op.byte_val = goto_byte;
			end
			ACT_CLEAR: begin
				op.kind     = OP_CLEAR;
				op.byte_val = CMD_CLEAR;
			end
			default: begin
				op.kind = OP_NONE;
			end
		endcase
	end

endmodule

@@ hw/rtl/clns_queue.sv @@
module clns_queue
	import clns_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output op_t  pop_op
);

	op_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign pop_op    = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/clns_back.sv @@
module clns_back
	import clns_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 q_valid,
	input  op_t                  q_op,
	output logic                 q_pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata
);

	logic [15:0] pulse_q, gap_q, settle_q, power_q;

	phase_t      ph_q, ph_n;
	logic [15:0] wc_q, wc_n;
	logic [7:0]  byte_q, byte_n;
	logic        rs_q, rs_n;
	logic [2:0]  step_q, step_n;
	logic        home_q, home_n;
	logic        done_q, done_n;
	logic        extra_q, extra_n;
	logic        acc;

	logic [15:0] dur;
	logic [16:0] len;
	logic        expired;
	logic [2:0]  step_inc;
	logic [3:0]  nib;
	logic        en;

	logic        out_valid_q;
	logic [7:0]  out_data_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q  <= RST_PULSE;
			gap_q    <= RST_GAP;
			settle_q <= RST_SETTLE;
			power_q  <= RST_POWER;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PULSE:  pulse_q  <= cfg_data;
				REG_GAP:    gap_q    <= cfg_data;
				REG_SETTLE: settle_q <= cfg_data;
				REG_POWER:  power_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Length of the current phase; a zero setting counts as one tick.
	always_comb begin
		case (ph_q)
			PH_POWER:        dur = power_q;
			PH_HIGH, PH_LOW: dur = pulse_q;
			PH_GAP:          dur = gap_q;
			default:         dur = settle_q;
		endcase
	end
	assign len      = (dur == 16'd0) ? 17'd1 : {1'b0, dur};
	assign expired  = ({1'b0, wc_q} + 17'd1) >= len;
	assign step_inc = step_q + 3'd1;

	// Take an item from the queue whenever the output register can be refilled.
	assign q_pop = q_valid && (!out_valid_q || m_tready);

	// Sequencer next state for the item at the head of the queue.
	always_comb begin
		logic do_next;
		do_next = 1'b0;
		ph_n    = ph_q;
		wc_n    = wc_q;
		byte_n  = byte_q;
		rs_n    = rs_q;
		step_n  = step_q;
		home_n  = home_q;
		done_n  = done_q;
		extra_n = extra_q;
		acc     = 1'b0;

		if (q_op.kind == OP_TICK) begin
			if (ph_q != PH_IDLE) begin
				if (!expired) begin
					wc_n = wc_q + 16'd1;
				end else begin
					wc_n = 16'd0;
					case (ph_q)
						PH_POWER: begin
							step_n  = 3'd0;
							byte_n  = init_byte(3'd0);
							rs_n    = 1'b0;
							extra_n = 1'b0;
							ph_n    = PH_HIGH;
						end
						PH_HIGH: ph_n = PH_GAP;
						PH_GAP:  ph_n = PH_LOW;
						PH_LOW:  ph_n = PH_SETTLE;
						PH_SETTLE: begin
							if (extra_q) begin
								extra_n = 1'b0;
								ph_n    = PH_EXTRA;
							end else begin
								do_next = 1'b1;
							end
						end
						default: do_next = 1'b1;
					endcase
				end
			end
		end else if (ph_q == PH_IDLE) begin
			case (q_op.kind)
				OP_START: begin
					byte_n  = q_op.byte_val;
					rs_n    = q_op.rs;
					extra_n = 1'b0;
					ph_n    = PH_HIGH;
					wc_n    = 16'd0;
					acc     = 1'b1;
				end
				OP_CLEAR: begin
					home_n  = 1'b1;
					byte_n  = CMD_CLEAR;
					rs_n    = 1'b0;
					extra_n = 1'b1;
					ph_n    = PH_HIGH;
					wc_n    = 16'd0;
					acc     = 1'b1;
				end
				default: ;
			endcase
		end

		// Pick the byte that follows a finished one.
		if (do_next) begin
			if (!done_q) begin
				step_n = step_inc;
				if (step_inc != INIT_COUNT) begin
					byte_n  = init_byte(step_inc);
					rs_n    = 1'b0;
					extra_n = (step_inc >= INIT_EXTRA);
					ph_n    = PH_HIGH;
				end else begin
					done_n = 1'b1;
					step_n = 3'd0;
					ph_n   = PH_IDLE;
				end
			end else if (home_q) begin
				home_n  = 1'b0;
				byte_n  = CMD_HOME;
				rs_n    = 1'b0;
				extra_n = 1'b0;
				ph_n    = PH_HIGH;
			end else begin
				ph_n = PH_IDLE;
			end
		end
	end

	// Bus levels after the item.
	assign nib = (ph_n == PH_HIGH || ph_n == PH_GAP) ? byte_n[7:4] : byte_n[3:0];
	assign en  = (ph_n == PH_HIGH || ph_n == PH_LOW);

	// Sequencer state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_POWER;
			wc_q    <= 16'd0;
			byte_q  <= 8'd0;
			rs_q    <= 1'b0;
			step_q  <= 3'd0;
			home_q  <= 1'b0;
			done_q  <= 1'b0;
			extra_q <= 1'b0;
		end else if (q_pop) begin
			ph_q    <= ph_n;
			wc_q    <= wc_n;
			byte_q  <= byte_n;
			rs_q    <= rs_n;
			step_q  <= step_n;
			home_q  <= home_n;
			done_q  <= done_n;
			extra_q <= extra_n;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_data_q <= {acc, (ph_n == PH_IDLE), en, rs_n, nib};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

@@ hw/rtl/char_lcd_nibble_sequencer_top.sv @@
// An accepted item is written into the queue; once it is at the head and the output
// register can be refilled, its result is registered there. A stalled output delays it.
// Throughput: one item per cycle while the output is not stalled.
// The two-entry queue and the output register hold items while the output is stalled; the
// input stops once both are full. Reset is asynchronous and active low: registers return to
// their defaults and the sequencer restarts in the power-on wait.
module char_lcd_nibble_sequencer_top
	import clns_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// s_tdata: [7:0] byte_value, [9:8] row, [14:10] column, [15] zero
	input  logic [15:0]          s_tdata,
	// s_tuser: [2:0] action
	input  logic [2:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// m_tdata: [3:0] data_nibble, [4] register_select, [5] enable, [6] ready_res,
	// [7] accepted
	output logic [7:0]           m_tdata
);

	op_t  dec_op;
	op_t  head_op;
	logic q_full;
	logic q_valid;
	logic q_pop;
	logic push;

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;

	// Decode side.
	clns_front u_front (
		.action     (s_tuser),
		.byte_value (s_tdata[7:0]),
		.row        (s_tdata[9:8]),
		.column     (s_tdata[14:10]),
		.op         (dec_op)
	);

	// Queue between decode and sequencer.
	clns_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (dec_op),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_op    (head_op)
	);

	// Sequencer and output register.
	clns_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_op      (head_op),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

@@ hw/rtl/clns_checker.sv @@
module clns_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
	else $error("stalled result changed");

	// The enable strobe is never high while the sequencer reports idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[5] && m_tdata[6]))
	else $error("enable high while idle");

	// A taken request starts a byte at once: enable high, no longer idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7] |-> m_tdata[5] && !m_tdata[6])
	else $error("accepted request did not start a byte");

	// Right after reset no result can be waiting.
	assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
	else $error("result present out of reset");

endmodule

bind char_lcd_nibble_sequencer_top clns_checker u_clns_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
